@@ rtl/core/cfbr_pkg.sv @@
// Shared types, constants and register map of the column framebuffer text renderer.
`default_nettype none
package cfbr_pkg;

  localparam int unsigned DISP_WIDTH  = 128;
  localparam int unsigned DISP_HEIGHT = 32;
  localparam int unsigned COL_AW      = $clog2(DISP_WIDTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_REGS    = 7;
  localparam int unsigned PADDR_W     = $clog2(CFG_REGS * 4);

  localparam logic [8:0] COL_LIMIT = 9'(DISP_WIDTH);
  localparam logic [6:0] ROW_LIMIT = 7'(DISP_HEIGHT);
  localparam logic [63:0] UNDERLINE_ROWS = 64'h0F;

  typedef logic [DISP_HEIGHT-1:0] word_t;
  typedef logic [COL_AW-1:0]      col_addr_t;

  localparam logic [2:0] REQ_SET_POS = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_PIXEL   = 3'd2;
  localparam logic [2:0] REQ_GLYPH   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  localparam logic [2:0] REG_DRAW_COLOR     = 3'd0;
  localparam logic [2:0] REG_TRANSPARENT_BG = 3'd1;
  localparam logic [2:0] REG_CURSOR_STYLE   = 3'd2;
  localparam logic [2:0] REG_EXTRA_SPACING  = 3'd3;
  localparam logic [2:0] REG_FONT_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_FONT_WIDTH     = 3'd5;
  localparam logic [2:0] REG_MONO_FONT      = 3'd6;

  localparam logic [1:0] CUR_FULL   = 2'd0;
  localparam logic [1:0] CUR_HEIGHT = 2'd1;
  localparam logic [1:0] CUR_UNDER  = 2'd2;

  typedef enum logic [2:0] {
    OP_REPLY,
    OP_CLEAR,
    OP_PIXEL,
    OP_GLYPH,
    OP_READ
  } op_e;

  typedef struct packed {
    logic       draw_color;
    logic       transparent_bg;
    logic [1:0] cursor_style;
    logic [3:0] extra_spacing;
    logic [5:0] font_height;
    logic [5:0] font_width;
    logic       mono_font;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic       status;
    col_addr_t  col;
    logic [4:0] row;
    logic [31:0] bits;
    logic       cursored;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/cfbr_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface cfbr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  x_coord;
  logic [4:0]  y_coord;
  logic [31:0] glyph_bits;
  logic        cursored;
  logic        last_column;

  modport source (output valid, req_type, x_coord, y_coord, glyph_bits, cursored,
                  last_column, input ready);
  modport sink (input valid, req_type, x_coord, y_coord, glyph_bits, cursored,
                last_column, output ready);
endinterface

interface cfbr_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] column_data;

  modport source (output valid, status, column_data, input ready);
  modport sink (input valid, status, column_data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/column_framebuffer_text_renderer_unit.sv @@
// Top level of the column framebuffer text renderer: register file, front end, queue, engine.
//
// Usage:
//   req_i carries one request per item (set position, clear, draw pixel, glyph column,
//   read column); rsp_o returns exactly one response item per request, in order, with
//   status and the column data of a read.
//   Registers are written over the APB port at byte address 4*index, by the user only while
//   the block is idle (unenforced); pready is always high, reads return the stored value.
// Timing:
//   An item is stored in the queue, where the engine pops it and reads the framebuffer,
//   then passes to the engine's modify step (write and response load), which registers
//   the response. The engine pops a new item only after the modify step of the last one
//   ends, as set by its read-modify-write of the framebuffer. Clear takes the same path:
//   it drops the per-column valid bits and records the fill word.
// Reset:
//   Cursor, glyph state and valid bits clear, so the whole framebuffer reads as zero.
//   Registers return to their defaults. No clearing pass is needed.
// Stall:
//   When rsp_o.ready is low the response holds; the engine waits in its modify step and
//   the two-entry queue keeps accepting requests until it fills, then req_i.ready drops.
`default_nettype none
module column_framebuffer_text_renderer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  cfbr_req_if.sink                           req_i,
  cfbr_rsp_if.source                         rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfbr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import cfbr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  cmd_t       push_cmd;
  cmd_t       head_cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_color     <= 1'b1;
      cfg_q.transparent_bg <= 1'b1;
      cfg_q.cursor_style   <= CUR_FULL;
      cfg_q.extra_spacing  <= 4'd1;
      cfg_q.font_height    <= 6'd8;
      cfg_q.font_width     <= 6'd5;
      cfg_q.mono_font      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DRAW_COLOR:     cfg_q.draw_color     <= pwdata[0];
        REG_TRANSPARENT_BG: cfg_q.transparent_bg <= pwdata[0];
        REG_CURSOR_STYLE:   cfg_q.cursor_style   <= pwdata[1:0];
        REG_EXTRA_SPACING:  cfg_q.extra_spacing  <= pwdata[3:0];
        REG_FONT_HEIGHT:    cfg_q.font_height    <= pwdata[5:0];
        REG_FONT_WIDTH:     cfg_q.font_width     <= pwdata[5:0];
        REG_MONO_FONT:      cfg_q.mono_font      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DRAW_COLOR:     prdata = {31'd0, cfg_q.draw_color};
      REG_TRANSPARENT_BG: prdata = {31'd0, cfg_q.transparent_bg};
      REG_CURSOR_STYLE:   prdata = {30'd0, cfg_q.cursor_style};
      REG_EXTRA_SPACING:  prdata = {28'd0, cfg_q.extra_spacing};
      REG_FONT_HEIGHT:    prdata = {26'd0, cfg_q.font_height};
      REG_FONT_WIDTH:     prdata = {26'd0, cfg_q.font_width};
      REG_MONO_FONT:      prdata = {31'd0, cfg_q.mono_font};
      default:            prdata = '0;
    endcase
  end

  cfbr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  cfbr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  cfbr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );
endmodule
`default_nettype wire

@@ rtl/core/cfbr_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cfbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/cfbr_front.sv @@
// Front end: accepts requests, tracks the text cursor and issues commands.
`default_nettype none
module cfbr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  cfbr_req_if.sink             req_i,
  input  wire cfbr_pkg::cfg_t  cfg_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output cfbr_pkg::cmd_t       cmd_o
);
  import cfbr_pkg::*;

  logic [7:0] cur_col_q, cur_col_d;
  logic [4:0] cur_row_q, cur_row_d;
  logic [5:0] cnt_q, cnt_d;
  logic       clip_q, clip_d;
  logic [8:0] col_sum;
  logic       clip;
  logic [7:0] adv;
  logic       x_ok;
  logic       y_ok;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    col_sum = {1'b0, cur_col_q} + {3'b000, cnt_q};
    clip    = clip_q || (col_sum >= COL_LIMIT);
    adv     = cfg_i.mono_font ? {2'b00, cfg_i.font_width}
                              : {2'b00, cnt_q} + 8'd1 + {4'b0000, cfg_i.extra_spacing};
    x_ok    = {1'b0, req_i.x_coord} < COL_LIMIT;
    y_ok    = {2'b00, req_i.y_coord} < ROW_LIMIT;

    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    cnt_d     = cnt_q;
    clip_d    = clip_q;

    cmd_o.op       = OP_REPLY;
    cmd_o.status   = 1'b0;
    cmd_o.col      = req_i.x_coord[COL_AW-1:0];
    cmd_o.row      = req_i.y_coord;
    cmd_o.bits     = req_i.glyph_bits;
    cmd_o.cursored = req_i.cursored;

    unique case (req_i.req_type)
      REQ_SET_POS: begin
        if (push_o) begin
          cur_col_d = req_i.x_coord;
          cur_row_d = req_i.y_coord;
          cnt_d     = '0;
          clip_d    = 1'b0;
        end
      end
      REQ_CLEAR: cmd_o.op = OP_CLEAR;
      REQ_PIXEL: begin
        if (x_ok && y_ok) begin
          cmd_o.op = OP_PIXEL;
        end else begin
          cmd_o.status = 1'b1;
        end
      end
      REQ_GLYPH: begin
        cmd_o.col    = col_sum[COL_AW-1:0];
        cmd_o.row    = cur_row_q;
        cmd_o.status = clip;
        cmd_o.op     = clip ? OP_REPLY : OP_GLYPH;
        if (push_o) begin
          if (req_i.last_column) begin
            if (!clip) begin
              cur_col_d = cur_col_q + adv;
            end
            cnt_d  = '0;
            clip_d = 1'b0;
          end else begin
            clip_d = clip;
            if (cnt_q != 6'd63) begin
              cnt_d = cnt_q + 6'd1;
            end
          end
        end
      end
      REQ_READ: begin
        if (x_ok) begin
          cmd_o.op = OP_READ;
        end else begin
          cmd_o.status = 1'b1;
        end
      end
      default: cmd_o.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      cnt_q     <= '0;
      clip_q    <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_q     <= cnt_d;
      clip_q    <= clip_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/cfbr_fifo.sv @@
// Command queue between the front end and the framebuffer engine.
`default_nettype none
module cfbr_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cfbr_pkg::cmd_t  cmd_i,
  input  wire logic            pop_i,
  output cfbr_pkg::cmd_t       cmd_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import cfbr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/cfbr_back.sv @@
// Framebuffer engine: per-command column read-modify-write, clear and read, and response register.
`default_nettype none
module cfbr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfbr_pkg::cfg_t  cfg_i,
  input  wire cfbr_pkg::cmd_t  cmd_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  cfbr_rsp_if.source           rsp_o
);
  import cfbr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MOD  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q;
  logic            hit_q;
  logic [DISP_WIDTH-1:0] valid_q, valid_d;
  word_t           fill_q, fill_d;
  word_t           rdata;
  word_t           old_w;
  word_t           new_w;
  logic            we;
  logic            out_free;
  logic            out_valid_q, out_valid_d;
  logic            status_q, status_d;
  logic [31:0]     data_q, data_d;
  logic [5:0]      fh;
  logic [63:0]     low_fh, cmask, bg64, b64, w64, p64, rd64;
  word_t           bg, word, pix;

  cfbr_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (DISP_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_q.col),
    .wdata_i (new_w),
    .re_i    (pop_o),
    .raddr_i (cmd_i.col),
    .rdata_o (rdata)
  );

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.column_data = data_q;

  always_comb begin
    fh = cfg_i.font_height;
    if (cfg_i.font_height < 6'd4) begin
      fh = 6'd4;
    end else if (cfg_i.font_height > 6'd32) begin
      fh = 6'd32;
    end
    low_fh = (64'd1 << fh) - 64'd1;
    case (cfg_i.cursor_style)
      CUR_HEIGHT: cmask = ~low_fh;
      CUR_UNDER:  cmask = ~(UNDERLINE_ROWS << (fh - 6'd4)) | ~low_fh;
      default:    cmask = '0;
    endcase
    bg64 = cfg_i.transparent_bg ? 64'd0 : (low_fh << cmd_q.row);
    b64  = cmd_q.cursored ? (~{32'd0, cmd_q.bits} ^ cmask) : {32'd0, cmd_q.bits};
    w64  = b64 << cmd_q.row;
    p64  = 64'd1 << cmd_q.row;
    bg   = bg64[DISP_HEIGHT-1:0];
    word = w64[DISP_HEIGHT-1:0];
    pix  = p64[DISP_HEIGHT-1:0];
    old_w = hit_q ? rdata : fill_q;
    rd64  = 64'(old_w);
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    fill_d      = fill_q;
    new_w       = old_w;
    we          = 1'b0;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    data_d      = data_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = cmd_q.status;
          data_d      = '0;
          unique case (cmd_q.op)
            OP_CLEAR: begin
              valid_d = '0;
              fill_d  = cfg_i.draw_color ? '0 : '1;
            end
            OP_PIXEL: begin
              we    = 1'b1;
              new_w = cfg_i.draw_color ? (old_w | pix) : (old_w & ~pix);
            end
            OP_GLYPH: begin
              we    = 1'b1;
              new_w = cfg_i.draw_color ? ((old_w & ~bg) | word) : ((old_w | bg) & ~word);
            end
            OP_READ:  data_d = rd64[31:0];
            default:  data_d = '0;
          endcase
          if (we) begin
            valid_d[cmd_q.col] = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
      hit_q <= valid_q[cmd_i.col];
    end
    status_q <= status_d;
    data_q   <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/cfbr_checker.sv @@
// Port-level checker for the column framebuffer text renderer, bound to the top level.
`default_nettype none
module cfbr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic        rsp_status_i,
  input wire logic [31:0] rsp_data_i
);
  logic [2:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = req_valid_i && req_ready_i;
  assign out_acc = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_data_i))
    else $error("response changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 3'd0)
    else $error("response without pending request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more items in flight than the block can hold");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i != 32'd0 |-> !rsp_status_i)
    else $error("column data returned with failing status");
endmodule

bind column_framebuffer_text_renderer_unit cfbr_checker u_cfbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.column_data)
);
`default_nettype wire
